FILE: sv/sfcm_pkg.sv
// ----------------------------------------------------------------------------
// sfcm_pkg
// shared types, constants and length helpers for the serial flash command
// master
// ----------------------------------------------------------------------------
`default_nettype none

package sfcm_pkg;

    localparam int ADDR_BITS   = 24;
    localparam int STATUS_BITS = 16;
    localparam int ADDR_IN_W   = 24;
    localparam int READ_W      = 16;
    localparam int OUT_BITS    = 16 + ADDR_BITS;
    localparam int CNT_W       = 6;

    localparam logic       MODE_TICK  = 1'b0;
    localparam logic       MODE_START = 1'b1;

    localparam logic [2:0] KIND_WREN   = 3'd0;
    localparam logic [2:0] KIND_STATUS = 3'd1;
    localparam logic [2:0] KIND_READ   = 3'd2;
    localparam logic [2:0] KIND_ERASE  = 3'd3;
    localparam logic [2:0] KIND_PROG   = 3'd4;

    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_ERASE = 8'h20;
    localparam logic [7:0] CMD_PROG  = 8'h02;

    typedef struct packed {
        logic                 mode;
        logic [2:0]           kind;
        logic [7:0]           status_command;
        logic [ADDR_IN_W-1:0] address;
        logic [7:0]           write_data;
        logic                 miso;
    } req_t;

    typedef struct packed {
        logic              chip_select_active;
        logic              mosi;
        logic              clock_pulse;
        logic [READ_W-1:0] read_value;
        logic              done_res;
        logic              rejected;
    } res_t;

    function automatic logic [CNT_W-1:0] write_len(input logic [2:0] kind);
        logic [CNT_W-1:0] len;
        case (kind)
            KIND_WREN, KIND_STATUS: len = CNT_W'(8);
            KIND_READ, KIND_ERASE:  len = CNT_W'(8 + ADDR_BITS);
            default:                len = CNT_W'(16 + ADDR_BITS);
        endcase
        return len;
    endfunction

    function automatic logic [CNT_W-1:0] read_len(input logic [2:0] kind);
        logic [CNT_W-1:0] len;
        case (kind)
            KIND_STATUS: len = CNT_W'(STATUS_BITS);
            KIND_READ:   len = CNT_W'(8);
            default:     len = '0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: sv/sfcm_if.sv
// ----------------------------------------------------------------------------
// sfcm_req_if / sfcm_res_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
`default_nettype none

interface sfcm_req_if;
    logic          valid;
    logic          ready;
    sfcm_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sfcm_res_if;
    logic          valid;
    logic          ready;
    sfcm_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/sfcm_engine.sv
// ----------------------------------------------------------------------------
// sfcm_engine
// transaction state and single-pass next-state logic for one request
// ----------------------------------------------------------------------------
`default_nettype none

module sfcm_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire sfcm_pkg::req_t req,
    output sfcm_pkg::res_t      res
);

    logic                             busy_reg, busy_next;
    logic [2:0]                       kind_reg, kind_next;
    logic [sfcm_pkg::CNT_W-1:0]       bit_count_reg, bit_count_next;
    logic [sfcm_pkg::OUT_BITS-1:0]    out_shift_reg, out_shift_next;
    logic [sfcm_pkg::READ_W-1:0]      in_shift_reg, in_shift_next;
    logic                             mosi_reg, mosi_next;

    logic [sfcm_pkg::CNT_W-1:0]       wr_len;
    logic [sfcm_pkg::CNT_W-1:0]       rd_len;
    logic [sfcm_pkg::CNT_W-1:0]       total_len;
    logic [31:0]                      addr_ext;
    logic [7:0]                       cmd;
    logic                             kind_ok;

    assign wr_len    = sfcm_pkg::write_len(kind_reg);
    assign rd_len    = sfcm_pkg::read_len(kind_reg);
    assign total_len = wr_len + rd_len;
    assign addr_ext  = 32'(req.address);

    always_comb
    begin
        case (req.kind)
            sfcm_pkg::KIND_WREN:   cmd = sfcm_pkg::CMD_WREN;
            sfcm_pkg::KIND_STATUS: cmd = req.status_command;
            sfcm_pkg::KIND_READ:   cmd = sfcm_pkg::CMD_READ;
            sfcm_pkg::KIND_ERASE:  cmd = sfcm_pkg::CMD_ERASE;
            default:               cmd = sfcm_pkg::CMD_PROG;
        endcase
        kind_ok = req.kind inside {sfcm_pkg::KIND_WREN, sfcm_pkg::KIND_STATUS,
                                   sfcm_pkg::KIND_READ, sfcm_pkg::KIND_ERASE,
                                   sfcm_pkg::KIND_PROG};
    end

    always_comb
    begin
        busy_next      = busy_reg;
        kind_next      = kind_reg;
        bit_count_next = bit_count_reg;
        out_shift_next = out_shift_reg;
        in_shift_next  = in_shift_reg;
        mosi_next      = mosi_reg;
        res            = '0;

        if (fire)
        begin
            if (req.mode == sfcm_pkg::MODE_START)
            begin
                if (busy_reg || !kind_ok)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    busy_next      = 1'b1;
                    kind_next      = req.kind;
                    bit_count_next = '0;
                    in_shift_next  = '0;
                    out_shift_next = '0;
                    out_shift_next[sfcm_pkg::OUT_BITS-1 -: 8] = cmd;
                    if (req.kind inside {sfcm_pkg::KIND_READ, sfcm_pkg::KIND_ERASE,
                                         sfcm_pkg::KIND_PROG})
                    begin
                        out_shift_next[sfcm_pkg::OUT_BITS-9 -: sfcm_pkg::ADDR_BITS] =
                            addr_ext[sfcm_pkg::ADDR_BITS-1:0];
                    end
                    if (req.kind == sfcm_pkg::KIND_PROG)
                    begin
                        out_shift_next[7:0] = req.write_data;
                    end
                end
            end
            else if (busy_reg)
            begin
                res.clock_pulse = 1'b1;
                if (bit_count_reg < wr_len)
                begin
                    mosi_next      = out_shift_reg[sfcm_pkg::OUT_BITS-1];
                    out_shift_next = {out_shift_reg[sfcm_pkg::OUT_BITS-2:0], 1'b0};
                end
                else
                begin
                    in_shift_next = {in_shift_reg[sfcm_pkg::READ_W-2:0], req.miso};
                end
                bit_count_next = bit_count_reg + 1'b1;
                if (bit_count_next >= total_len)
                begin
                    busy_next    = 1'b0;
                    res.done_res = 1'b1;
                    if (rd_len != '0)
                    begin
                        res.read_value = in_shift_next;
                    end
                end
            end
        end

        res.chip_select_active = busy_next;
        res.mosi               = mosi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            kind_reg      <= '0;
            bit_count_reg <= '0;
            out_shift_reg <= '0;
            in_shift_reg  <= '0;
            mosi_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            kind_reg      <= kind_next;
            bit_count_reg <= bit_count_next;
            out_shift_reg <= out_shift_next;
            in_shift_reg  <= in_shift_next;
            mosi_reg      <= mosi_next;
        end
    end

    // count never reaches the transaction length while selected
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (bit_count_reg < total_len))
        else $error("bit count past transaction length");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.done_res) |=> !busy_reg)
        else $error("chip select held after done");

    a_reject_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.rejected) |=>
            ($stable(busy_reg) && $stable(kind_reg) && $stable(bit_count_reg)
             && $stable(out_shift_reg) && $stable(mosi_reg)))
        else $error("rejected request changed state");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req.mode == sfcm_pkg::MODE_TICK && !busy_reg) |=>
            (!busy_reg && $stable(mosi_reg)))
        else $error("tick while idle changed state");

endmodule

`default_nettype wire

FILE: sv/sfcm_out_reg.sv
// ----------------------------------------------------------------------------
// sfcm_out_reg
// result register between the engine and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module sfcm_out_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire sfcm_pkg::res_t load_data,
    output logic                load_ready,
    sfcm_res_if.source          res
);

    logic           valid_reg, valid_next;
    sfcm_pkg::res_t data_reg;

    assign load_ready = !valid_reg || res.ready;
    assign valid_next = load || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign res.valid = valid_reg;
    assign res.data  = data_reg;

endmodule

`default_nettype wire

FILE: sv/spi_flash_command_master.sv
// ----------------------------------------------------------------------------
// spi_flash_command_master
// serial flash command master: start requests load a transaction, tick
// requests advance it by one serial clock period
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after its request is accepted
// throughput: one request per cycle while the result channel keeps up;
// a request is taken while the result register is empty or being drained
// reset: asynchronous, active low; idle, chip deselected, mosi low, no result
// ----------------------------------------------------------------------------
`default_nettype none

module spi_flash_command_master (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfcm_req_if.sink   req,
    sfcm_res_if.source res
);

    logic           fire;
    logic           load_ready;
    sfcm_pkg::res_t res_c;

    assign req.ready = load_ready;
    assign fire      = req.valid && load_ready;

    sfcm_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req.data),
        .res   (res_c)
    );

    sfcm_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .load_data  (res_c),
        .load_ready (load_ready),
        .res        (res)
    );

endmodule

`default_nettype wire

FILE: bench/sfcm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfcm_checker
// watches the request and result channels of the serial flash command master,
// predicts each result from its own copy of the transaction state and compares
// it field by field with what the block returns, in order
// ----------------------------------------------------------------------------
module sfcm_checker (
    input  logic clk,
    input  logic rst_n,
    sfcm_req_if  req,
    sfcm_res_if  res,
    output int   fail_count,
    output int   pending,
    output int   checked_count,
    output int   done_count,
    output int   refused_count
);

    // flash transaction state
    logic                          flash_busy;
    logic [2:0]                    cur_kind;
    int                            bits_done;
    logic [sfcm_pkg::OUT_BITS-1:0] tx_bits;
    logic [sfcm_pkg::READ_W-1:0]   rx_bits;
    logic                          mosi_q;

    sfcm_pkg::res_t expected_q[$];

    function automatic int send_bits(input logic [2:0] k);
        case (k)
            sfcm_pkg::KIND_WREN, sfcm_pkg::KIND_STATUS: return 8;
            sfcm_pkg::KIND_READ, sfcm_pkg::KIND_ERASE:  return 8 + sfcm_pkg::ADDR_BITS;
            default:                                    return 16 + sfcm_pkg::ADDR_BITS;
        endcase
    endfunction

    function automatic int recv_bits(input logic [2:0] k);
        case (k)
            sfcm_pkg::KIND_STATUS: return sfcm_pkg::STATUS_BITS;
            sfcm_pkg::KIND_READ:   return 8;
            default:               return 0;
        endcase
    endfunction

    task automatic predict_flash(input sfcm_pkg::req_t r, output sfcm_pkg::res_t e);
        logic [7:0] opcode;
        int         wl;
        int         total;
        e = '0;
        if (r.mode == sfcm_pkg::MODE_START)
        begin
            if (flash_busy || r.kind > sfcm_pkg::KIND_PROG)
            begin
                e.rejected = 1'b1;
            end
            else
            begin
                case (r.kind)
                    sfcm_pkg::KIND_WREN:   opcode = sfcm_pkg::CMD_WREN;
                    sfcm_pkg::KIND_STATUS: opcode = r.status_command;
                    sfcm_pkg::KIND_READ:   opcode = sfcm_pkg::CMD_READ;
                    sfcm_pkg::KIND_ERASE:  opcode = sfcm_pkg::CMD_ERASE;
                    default:               opcode = sfcm_pkg::CMD_PROG;
                endcase
                flash_busy = 1'b1;
                cur_kind   = r.kind;
                bits_done  = 0;
                rx_bits    = '0;
                tx_bits    = '0;
                tx_bits[sfcm_pkg::OUT_BITS-1 -: 8] = opcode;
                if (r.kind >= sfcm_pkg::KIND_READ)
                    tx_bits[sfcm_pkg::OUT_BITS-9 -: sfcm_pkg::ADDR_BITS] =
                        r.address[sfcm_pkg::ADDR_BITS-1:0];
                if (r.kind == sfcm_pkg::KIND_PROG)
                    tx_bits[7:0] = r.write_data;
            end
        end
        else if (flash_busy)
        begin
            wl    = send_bits(cur_kind);
            total = wl + recv_bits(cur_kind);
            e.clock_pulse = 1'b1;
            if (bits_done < wl)
            begin
                mosi_q  = tx_bits[sfcm_pkg::OUT_BITS-1];
                tx_bits = tx_bits << 1;
            end
            else
            begin
                rx_bits = {rx_bits[sfcm_pkg::READ_W-2:0], r.miso};
            end
            bits_done++;
            if (bits_done >= total)
            begin
                flash_busy   = 1'b0;
                e.done_res   = 1'b1;
                e.read_value = (recv_bits(cur_kind) != 0) ? rx_bits : '0;
            end
        end
        e.chip_select_active = flash_busy;
        e.mosi               = mosi_q;
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sfcm_pkg::res_t e;
        sfcm_pkg::res_t got;
        if (!rst_n)
        begin
            flash_busy    = 1'b0;
            cur_kind      = sfcm_pkg::KIND_WREN;
            bits_done     = 0;
            tx_bits       = '0;
            rx_bits       = '0;
            mosi_q        = 1'b0;
            expected_q.delete();
            fail_count    = 0;
            pending       = 0;
            checked_count = 0;
            done_count    = 0;
            refused_count = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = res.data;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result %0h with no request outstanding", $time, got);
                end
                else
                begin
                    e = expected_q.pop_front();
                    check_field("chip_select_active", int'(e.chip_select_active),
                                int'(got.chip_select_active));
                    check_field("mosi", int'(e.mosi), int'(got.mosi));
                    check_field("clock_pulse", int'(e.clock_pulse), int'(got.clock_pulse));
                    check_field("read_value", int'(e.read_value), int'(got.read_value));
                    check_field("done_res", int'(e.done_res), int'(got.done_res));
                    check_field("rejected", int'(e.rejected), int'(got.rejected));
                    checked_count++;
                    if (e.done_res)
                        done_count++;
                    if (e.rejected)
                        refused_count++;
                end
            end
            if (req.valid && req.ready)
            begin
                predict_flash(req.data, e);
                expected_q.push_back(e);
            end
            pending = expected_q.size();
        end
    end

endmodule

FILE: bench/tb_spi_flash_command_master.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spi_flash_command_master
// drives start and tick requests into the serial flash command master:
// idle ticks, refused starts, then every transaction kind with extreme
// fields, then random well-formed transactions mixed with noise and cut-short
// sequences; the sender runs in bursts and the receiver stalls on its own
// pattern; results are checked by sfcm_checker
// ----------------------------------------------------------------------------
module tb_spi_flash_command_master;

    localparam logic [2:0] KIND_MAX_CODE = 3'd7;
    localparam int         TOTAL_ITEMS   = 650;

    logic clk;
    logic rst_n;
    logic req_taken;
    bit   hold_off_req;
    int   sent_count;
    int   burst_left;
    int   txn_count;

    int fail_count;
    int pending;
    int checked_count;
    int done_count;
    int refused_count;

    sfcm_req_if req_ch ();
    sfcm_res_if res_ch ();

    spi_flash_command_master dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    sfcm_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .res           (res_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .done_count    (done_count),
        .refused_count (refused_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
            req_taken <= req_ch.valid && req_ch.ready;
    end

    function automatic logic [31:0] field_value(input int bits);
        logic [31:0] mask;
        mask = (32'h1 << bits) - 32'h1;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return mask;
            default: return $urandom & mask;
        endcase
    endfunction

    function automatic sfcm_pkg::req_t tick_req(input logic bit_in);
        sfcm_pkg::req_t r;
        logic [31:0]    raw;
        raw              = $urandom;
        r.mode           = sfcm_pkg::MODE_TICK;
        r.kind           = 3'($urandom);
        r.status_command = 8'($urandom);
        r.address        = raw[sfcm_pkg::ADDR_IN_W-1:0];
        r.write_data     = 8'($urandom);
        r.miso           = bit_in;
        return r;
    endfunction

    function automatic sfcm_pkg::req_t start_req(input logic [2:0] kind,
                                                 input logic [7:0] scmd,
                                                 input logic [sfcm_pkg::ADDR_IN_W-1:0] addr,
                                                 input logic [7:0] wdat);
        sfcm_pkg::req_t r;
        r.mode           = sfcm_pkg::MODE_START;
        r.kind           = kind;
        r.status_command = scmd;
        r.address        = addr;
        r.write_data     = wdat;
        r.miso           = 1'($urandom);
        return r;
    endfunction

    function automatic sfcm_pkg::req_t random_start(input logic [2:0] lo,
                                                    input logic [2:0] hi);
        logic [31:0] raw;
        raw = $urandom;
        return start_req(3'($urandom_range(32'(lo), 32'(hi))), 8'($urandom),
                         raw[sfcm_pkg::ADDR_IN_W-1:0], 8'($urandom));
    endfunction

    // offer one request, hold it until taken, then keep bursting or idle
    task automatic send(input sfcm_pkg::req_t r);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(negedge clk);
        while (!req_taken)
            @(negedge clk);
        sent_count++;
        if (sent_count == 300)
            hold_off_req = 1'b1;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(30, 80))
                                                     : int'($urandom_range(0, 8));
        end
    endtask

    task automatic drain;
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic run_flash_op(input logic [2:0] kind, input logic [7:0] scmd,
                                input logic [sfcm_pkg::ADDR_IN_W-1:0] addr,
                                input logic [7:0] wdat, input bit noisy);
        int n;
        n = int'(sfcm_pkg::write_len(kind)) + int'(sfcm_pkg::read_len(kind));
        if (noisy && $urandom_range(0, 9) == 0)
            n = int'($urandom_range(0, n));
        send(start_req(kind, scmd, addr, wdat));
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send(random_start(sfcm_pkg::KIND_WREN, KIND_MAX_CODE));
            send(tick_req(1'($urandom_range(0, 1))));
        end
        txn_count++;
    endtask

    // receiver: ready pattern changes after stretches of random length, one long hold-off
    initial
    begin
        int style;
        int style_left;
        int stall_left;
        int beat;
        res_ch.ready = 1'b0;
        style        = 0;
        style_left   = 0;
        stall_left   = 0;
        beat         = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            beat++;
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = 80;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = int'($urandom_range(0, 3));
                    style_left = int'($urandom_range(20, 100));
                end
                style_left--;
                case (style)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= (beat % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [2:0]  k;
        logic [31:0] addr_pick;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rst_n        = 1'b0;
        hold_off_req = 1'b0;
        sent_count   = 0;
        burst_left   = 0;
        txn_count    = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // idle tick, unknown kinds, start while busy, short transaction
        send(tick_req(1'b1));
        send(start_req(sfcm_pkg::KIND_PROG + 3'd1, 8'hFF, '1, 8'hFF));
        send(start_req(KIND_MAX_CODE, 8'h00, '0, 8'h00));
        send(start_req(sfcm_pkg::KIND_WREN, 8'hFF, '1, 8'hFF));
        send(start_req(sfcm_pkg::KIND_PROG, 8'hFF, '1, 8'hFF));
        for (int i = 0; i < 8; i++)
            send(tick_req(i[0]));
        send(tick_req(1'b0));
        drain;

        // every kind with extreme fields
        for (int i = int'(sfcm_pkg::KIND_WREN); i <= int'(sfcm_pkg::KIND_PROG); i++)
        begin
            k = 3'(i);
            run_flash_op(k, i[0] ? 8'hFF : 8'h00, i[0] ? '0 : '1,
                         i[0] ? 8'h00 : 8'hFF, 1'b0);
        end
        drain;

        while (sent_count < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                addr_pick = field_value(sfcm_pkg::ADDR_IN_W);
                run_flash_op(3'($urandom_range(32'(sfcm_pkg::KIND_WREN),
                                               32'(sfcm_pkg::KIND_PROG))),
                             8'(field_value(8)),
                             addr_pick[sfcm_pkg::ADDR_IN_W-1:0], 8'(field_value(8)),
                             $urandom_range(0, 2) == 0);
                if (txn_count % 6 == 0)
                    drain;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                repeat ($urandom_range(1, 4)) send(tick_req(1'($urandom_range(0, 1))));
            end
            else
            begin
                send(random_start(sfcm_pkg::KIND_PROG + 3'd1, KIND_MAX_CODE));
            end
        end

        drain;
        repeat (4) @(negedge clk);
        $display("%0d results checked over %0d flash operations", checked_count, txn_count);
        $display("%0d operations completed, %0d start requests refused",
                 done_count, refused_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
